// ----- hdl/xtb_pkg.sv -----
package xtb_pkg;

   // Store sizes
   localparam int CHAR_STORE_DEPTH = 4096;
   localparam int MAX_NESTING      = 256;

   localparam int CHAR_AW = $clog2(CHAR_STORE_DEPTH);
   localparam int NEST_AW = $clog2(MAX_NESTING);
   localparam int CTOP_W  = CHAR_AW + 1;   // holds 0 .. CHAR_STORE_DEPTH
   localparam int DEPTH_W = NEST_AW + 1;   // holds 0 .. MAX_NESTING

   // Delimiters
   localparam logic [7:0] BYTE_LT    = 8'h3C;
   localparam logic [7:0] BYTE_GT    = 8'h3E;
   localparam logic [7:0] BYTE_SLASH = 8'h2F;

   typedef enum logic [1:0] {
      MODE_OUTSIDE = 2'd0,
      MODE_FIRST   = 2'd1,
      MODE_OPEN    = 2'd2,
      MODE_CLOSE   = 2'd3
   } scan_mode_type;

   typedef enum logic [2:0] {
      ERR_NONE         = 3'd0,
      ERR_MISMATCH     = 3'd1,
      ERR_UNCLOSED     = 3'd2,
      ERR_UNTERMINATED = 3'd3,
      ERR_OVERFLOW     = 3'd4
   } err_kind_type;

   typedef struct packed {
      logic       consistent;
      logic [2:0] error_kind;
      logic [8:0] open_depth;
   } rsp_type;

endpackage

// ----- hdl/xtb_req_if.sv -----
interface xtb_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ----- hdl/xtb_rsp_if.sv -----
interface xtb_rsp_if;
   logic       valid;
   logic       ready;
   logic       consistent;
   logic [2:0] error_kind;
   logic [8:0] open_depth;

   modport source (output valid, output consistent, output error_kind, output open_depth,
                   input ready);
   modport sink   (input valid, input consistent, input error_kind, input open_depth,
                   output ready);
endinterface

// ----- hdl/xtb_ram.sv -----
module xtb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

// ----- hdl/xtb_scan.sv -----
module xtb_scan (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [7:0]                    in_data_byte,
   input  logic                          in_last_byte,
   output logic                          out_valid,
   input  logic                          out_ready,
   output xtb_pkg::rsp_type              out_item,
   output logic                          char_wr_en,
   output logic [xtb_pkg::CHAR_AW-1:0]   char_wr_addr,
   output logic [7:0]                    char_wr_data,
   output logic                          char_rd_en,
   output logic [xtb_pkg::CHAR_AW-1:0]   char_rd_addr,
   input  logic [7:0]                    char_rd_data,
   output logic                          start_wr_en,
   output logic [xtb_pkg::NEST_AW-1:0]   start_wr_addr,
   output logic [xtb_pkg::CTOP_W-1:0]    start_wr_data,
   output logic                          start_rd_en,
   output logic [xtb_pkg::NEST_AW-1:0]   start_rd_addr,
   input  logic [xtb_pkg::CTOP_W-1:0]    start_rd_data
);

   localparam int CTOP_W  = xtb_pkg::CTOP_W;
   localparam int DEPTH_W = xtb_pkg::DEPTH_W;
   localparam int CHAR_AW = xtb_pkg::CHAR_AW;
   localparam int NEST_AW = xtb_pkg::NEST_AW;

   xtb_pkg::scan_mode_type mode_ff, mode_in;
   xtb_pkg::err_kind_type  failed_ff, failed_in, kind;
   logic [CTOP_W-1:0]  char_top_ff, char_top_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic [CTOP_W-1:0]  offset_ff, offset_in;
   logic [CTOP_W-1:0]  top_start_ff, top_start_in;
   logic [CTOP_W-1:0]  open_start_ff, open_start_in;
   logic               pop_pending_ff, pop_pending_in;
   logic               rsp_valid_ff, rsp_valid_in;
   xtb_pkg::rsp_type   rsp_item_ff, rsp_item_in;

   logic               accept;
   logic               last_accept;
   logic [CTOP_W-1:0]  top_len;
   logic [CTOP_W-1:0]  offset_next;
   logic               char_full;
   logic               nest_full;

   assign in_ready    = !rsp_valid_ff || out_ready;
   assign accept      = in_valid && in_ready;
   assign last_accept = accept && in_last_byte;
   assign top_len     = char_top_ff - top_start_ff;
   assign offset_next = offset_ff + CTOP_W'(1);
   assign char_full   = char_top_ff >= CTOP_W'(xtb_pkg::CHAR_STORE_DEPTH);
   assign nest_full   = depth_ff >= DEPTH_W'(xtb_pkg::MAX_NESTING);

   assign out_valid = rsp_valid_ff;
   assign out_item  = rsp_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= xtb_pkg::MODE_OUTSIDE;
         failed_ff      <= xtb_pkg::ERR_NONE;
         char_top_ff    <= '0;
         depth_ff       <= '0;
         offset_ff      <= '0;
         pop_pending_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         mode_ff        <= mode_in;
         failed_ff      <= failed_in;
         char_top_ff    <= char_top_in;
         depth_ff       <= depth_in;
         offset_ff      <= offset_in;
         pop_pending_ff <= pop_pending_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_start_ff  <= top_start_in;
      open_start_ff <= open_start_in;
      rsp_item_ff   <= rsp_item_in;
   end

   always_comb begin
      mode_in        = mode_ff;
      failed_in      = failed_ff;
      char_top_in    = char_top_ff;
      depth_in       = depth_ff;
      offset_in      = offset_ff;
      top_start_in   = top_start_ff;
      open_start_in  = open_start_ff;
      pop_pending_in = 1'b0;
      rsp_item_in    = rsp_item_ff;
      kind           = xtb_pkg::ERR_NONE;

      char_wr_en    = 1'b0;
      char_wr_addr  = char_top_ff[CHAR_AW-1:0];
      char_wr_data  = in_data_byte;
      char_rd_en    = 1'b0;
      char_rd_addr  = top_start_ff[CHAR_AW-1:0];
      start_wr_en   = 1'b0;
      start_wr_addr = depth_ff[NEST_AW-1:0];
      start_wr_data = char_top_ff;
      start_rd_en   = 1'b0;
      start_rd_addr = NEST_AW'(depth_ff - DEPTH_W'(2));

      // start of the new top tag arrives from the start RAM in the cycle after a pop
      if (pop_pending_ff) begin
         top_start_in = start_rd_data;
      end

      if (accept && failed_ff == xtb_pkg::ERR_NONE) begin
         unique case (mode_ff)
            xtb_pkg::MODE_OUTSIDE: begin
               if (in_data_byte == xtb_pkg::BYTE_LT) begin
                  mode_in = xtb_pkg::MODE_FIRST;
               end
            end
            xtb_pkg::MODE_FIRST: begin
               if (in_data_byte == xtb_pkg::BYTE_SLASH) begin
                  if (depth_ff == '0) begin
                     failed_in = xtb_pkg::ERR_MISMATCH;
                  end else begin
                     offset_in  = '0;
                     mode_in    = xtb_pkg::MODE_CLOSE;
                     char_rd_en = 1'b1;   // prefetch first char of top tag
                  end
               end else if (nest_full) begin
                  failed_in = xtb_pkg::ERR_OVERFLOW;
               end else begin
                  start_wr_en   = 1'b1;
                  open_start_in = char_top_ff;
                  if (in_data_byte == xtb_pkg::BYTE_GT) begin
                     depth_in     = depth_ff + DEPTH_W'(1);
                     top_start_in = char_top_ff;
                     mode_in      = xtb_pkg::MODE_OUTSIDE;
                  end else begin
                     mode_in = xtb_pkg::MODE_OPEN;
                     if (char_full) begin
                        failed_in = xtb_pkg::ERR_OVERFLOW;
                     end else begin
                        char_wr_en  = 1'b1;
                        char_top_in = char_top_ff + CTOP_W'(1);
                     end
                  end
               end
            end
            xtb_pkg::MODE_OPEN: begin
               if (in_data_byte == xtb_pkg::BYTE_GT) begin
                  depth_in     = depth_ff + DEPTH_W'(1);
                  top_start_in = open_start_ff;
                  mode_in      = xtb_pkg::MODE_OUTSIDE;
               end else if (char_full) begin
                  failed_in = xtb_pkg::ERR_OVERFLOW;
               end else begin
                  char_wr_en  = 1'b1;
                  char_top_in = char_top_ff + CTOP_W'(1);
               end
            end
            xtb_pkg::MODE_CLOSE: begin
               if (in_data_byte == xtb_pkg::BYTE_GT) begin
                  if (offset_ff != top_len) begin
                     failed_in = xtb_pkg::ERR_MISMATCH;
                  end else begin
                     char_top_in    = top_start_ff;
                     depth_in       = depth_ff - DEPTH_W'(1);
                     offset_in      = '0;
                     mode_in        = xtb_pkg::MODE_OUTSIDE;
                     start_rd_en    = 1'b1;
                     pop_pending_in = 1'b1;
                  end
               end else if (offset_ff >= top_len || char_rd_data != in_data_byte) begin
                  failed_in = xtb_pkg::ERR_MISMATCH;
               end else begin
                  offset_in    = offset_next;
                  char_rd_en   = 1'b1;
                  char_rd_addr = CHAR_AW'(top_start_ff + offset_next);
               end
            end
            default: begin
               mode_in = xtb_pkg::MODE_OUTSIDE;
            end
         endcase
      end

      if (last_accept) begin
         priority if (failed_in != xtb_pkg::ERR_NONE) begin
            kind = failed_in;
         end else if (mode_in != xtb_pkg::MODE_OUTSIDE) begin
            kind = xtb_pkg::ERR_UNTERMINATED;
         end else if (depth_in != '0) begin
            kind = xtb_pkg::ERR_UNCLOSED;
         end else begin
            kind = xtb_pkg::ERR_NONE;
         end
         rsp_item_in.consistent = (kind == xtb_pkg::ERR_NONE);
         rsp_item_in.error_kind = kind;
         rsp_item_in.open_depth = (32'(depth_in) > 32'd511) ? 9'd511 : 9'(depth_in);

         // back to the idle document state
         mode_in        = xtb_pkg::MODE_OUTSIDE;
         failed_in      = xtb_pkg::ERR_NONE;
         char_top_in    = '0;
         depth_in       = '0;
         offset_in      = '0;
         pop_pending_in = 1'b0;
      end

      rsp_valid_in = (rsp_valid_ff && !out_ready) || last_accept;
   end

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DEPTH_W'(xtb_pkg::MAX_NESTING))
      else $error("nesting depth above store size");

   a_char_bound: assert property (@(posedge clock) disable iff (reset)
      char_top_ff <= CTOP_W'(xtb_pkg::CHAR_STORE_DEPTH))
      else $error("char top above store size");

   a_close_nonempty: assert property (@(posedge clock) disable iff (reset)
      mode_ff == xtb_pkg::MODE_CLOSE |-> depth_ff != '0)
      else $error("closing tag compare with empty stack");

   a_close_offset: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == xtb_pkg::MODE_CLOSE && failed_ff == xtb_pkg::ERR_NONE)
      |-> offset_ff <= top_len)
      else $error("compare offset past top tag");

   a_pop_refill: assert property (@(posedge clock) disable iff (reset)
      pop_pending_ff |-> mode_ff == xtb_pkg::MODE_OUTSIDE)
      else $error("top start refill overlaps tag scan");

endmodule

// ----- hdl/xml_tag_balance_checker_core.sv -----
// XML tag balance checker. Bytes of one document enter on req_bus, one item
// per byte, with last_byte set on the final byte; exactly one verdict item
// leaves on rsp_bus for each document, in the cycle after its last byte is
// taken, and the checker is then ready for the next document with no gap.
// Throughput is one byte per clock while req_bus ready is high. That rate
// is set by the tag character RAM: each byte of a closing tag needs one
// read of its stored counterpart, and that read is issued while the
// previous byte is consumed, so the data is waiting when the byte arrives.
// After a closing tag pops the stack, the start offset of the new top tag
// comes back from the tag start RAM in the next cycle and is then
// registered in time for the earliest next closing tag, which must open
// with '<'. The verdict sits in an output register; while it waits and the
// receiver holds ready low, req_bus ready drops and bytes stall. A verdict
// taken in the same cycle frees the register for the next one. Neither RAM
// needs clearing after reset: only entries written by the current document
// are ever used. error_kind codes: none, closing mismatch, unclosed tags,
// unterminated tag, store overflow; the first error wins and open_depth is
// frozen at that point.
module xml_tag_balance_checker_core (
   input  logic      clock,
   input  logic      reset,
   xtb_req_if.sink   req_bus,
   xtb_rsp_if.source rsp_bus
);

   logic                        char_wr_en;
   logic [xtb_pkg::CHAR_AW-1:0] char_wr_addr;
   logic [7:0]                  char_wr_data;
   logic                        char_rd_en;
   logic [xtb_pkg::CHAR_AW-1:0] char_rd_addr;
   logic [7:0]                  char_rd_data;

   logic                        start_wr_en;
   logic [xtb_pkg::NEST_AW-1:0] start_wr_addr;
   logic [xtb_pkg::CTOP_W-1:0]  start_wr_data;
   logic                        start_rd_en;
   logic [xtb_pkg::NEST_AW-1:0] start_rd_addr;
   logic [xtb_pkg::CTOP_W-1:0]  start_rd_data;

   xtb_pkg::rsp_type            rsp_item;

   // scanner: mode tracking, compare, stack pointers, verdict register
   xtb_scan u_scan (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_bus.valid),
      .in_ready      (req_bus.ready),
      .in_data_byte  (req_bus.data_byte),
      .in_last_byte  (req_bus.last_byte),
      .out_valid     (rsp_bus.valid),
      .out_ready     (rsp_bus.ready),
      .out_item      (rsp_item),
      .char_wr_en    (char_wr_en),
      .char_wr_addr  (char_wr_addr),
      .char_wr_data  (char_wr_data),
      .char_rd_en    (char_rd_en),
      .char_rd_addr  (char_rd_addr),
      .char_rd_data  (char_rd_data),
      .start_wr_en   (start_wr_en),
      .start_wr_addr (start_wr_addr),
      .start_wr_data (start_wr_data),
      .start_rd_en   (start_rd_en),
      .start_rd_addr (start_rd_addr),
      .start_rd_data (start_rd_data)
   );

   // open tag text, back to back
   xtb_ram #(
      .WIDTH (8),
      .DEPTH (xtb_pkg::CHAR_STORE_DEPTH)
   ) u_char_ram (
      .clock      (clock),
      .wr_en      (char_wr_en),
      .wr_addr    (char_wr_addr),
      .wr_data    (char_wr_data),
      .rd_en      (char_rd_en),
      .rd_addr    (char_rd_addr),
      .rd_data_ff (char_rd_data)
   );

   // start offset of each open tag in the char RAM, indexed by level
   xtb_ram #(
      .WIDTH (xtb_pkg::CTOP_W),
      .DEPTH (xtb_pkg::MAX_NESTING)
   ) u_start_ram (
      .clock      (clock),
      .wr_en      (start_wr_en),
      .wr_addr    (start_wr_addr),
      .wr_data    (start_wr_data),
      .rd_en      (start_rd_en),
      .rd_addr    (start_rd_addr),
      .rd_data_ff (start_rd_data)
   );

   assign rsp_bus.consistent = rsp_item.consistent;
   assign rsp_bus.error_kind = rsp_item.error_kind;
   assign rsp_bus.open_depth = rsp_item.open_depth;

endmodule
